/* rtl/lss_pkg.sv */
package lss_pkg;

	localparam int WORD_W    = 32;
	localparam int OP_W      = 3;
	localparam int CAP_W     = 7;
	localparam int DEPTH_DEF = 64;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
	localparam logic [OP_W-1:0] OP_POP     = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
	localparam logic [OP_W-1:0] OP_REVERSE = 3'd3;
	localparam logic [OP_W-1:0] OP_MIN     = 3'd4;
	localparam logic [OP_W-1:0] OP_MAX     = 3'd5;
	localparam logic [OP_W-1:0] OP_MEAN    = 3'd6;

	typedef logic [OP_W-1:0]          op_t;
	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CAP_W-1:0]         cap_t;

endpackage

/* rtl/lss_in_if.sv */
interface lss_in_if;
	logic            valid;
	logic            ready;
	lss_pkg::op_t    operation;
	lss_pkg::word_t  value_in;

	modport source (output valid, output operation, output value_in, input ready);
	modport sink   (input valid, input operation, input value_in, output ready);
endinterface

/* rtl/lss_out_if.sv */
interface lss_out_if;
	logic            valid;
	logic            ready;
	logic            ok;
	lss_pkg::word_t  value_out;
	logic            is_empty;
	logic            is_full;

	modport source (output valid, output ok, output value_out, output is_empty,
		output is_full, input ready);
	modport sink   (input valid, input ok, input value_out, input is_empty,
		input is_full, output ready);
endinterface

/* rtl/lifo_stack_with_stats.sv */
// Bounded LIFO stack of signed 32-bit words with min, max and mean.
// req carries one command (operation, value_in) per transfer; rsp returns
// exactly one result per command (ok, value_out, is_empty, is_full), in order.
// cfg_wr_en/cfg_wr_data write capacity_limit; write it only while idle.
// One command is in flight at a time: req.ready is high only while the
// sequencer is idle. A push needs no memory read, pop and peek do one
// registered memory read, reverse does two reads and two writes for each
// of the floor(n/2) swapped pairs (n = entries), min and max walk all n
// entries, and mean walks them and then runs 32 + clog2(DEPTH+1) divide steps.
// The next command is taken only once the sequencer has handed its
// result to the rsp register and returned to idle.
// Every walk goes through the single memory port pair; min, max and mean
// use the one shared adder/subtractor, which also runs the mean's restoring divide.
// A finished result sits in the rsp register; the next command is taken
// while it waits, and a stalled receiver holds the sequencer only at the
// point where its next result must be loaded.
// Reset clears the entry count, loads capacity_limit with 64 and drops any
// pending result; the entry memory itself is not cleared.
module lifo_stack_with_stats #(
	parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  lss_pkg::cap_t       cfg_wr_data,
	lss_in_if.sink              req,
	lss_out_if.source           rsp
);

	localparam int CW   = $clog2(DEPTH + 1);            // entry count width
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WW   = lss_pkg::WORD_W;
	localparam int SW   = WW + CW;                      // sum and dividend width
	localparam int AL   = SW + 1;                       // shared adder width
	localparam int STW  = $clog2(SW);
	localparam int CMPW = (CW > lss_pkg::CAP_W) ? CW : lss_pkg::CAP_W;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_LOAD    = 4'd1;
	localparam logic [3:0] S_SCAN_RD = 4'd2;
	localparam logic [3:0] S_SCAN_OP = 4'd3;
	localparam logic [3:0] S_ABS     = 4'd4;
	localparam logic [3:0] S_DIV     = 4'd5;
	localparam logic [3:0] S_NEG     = 4'd6;
	localparam logic [3:0] S_REV_A   = 4'd7;
	localparam logic [3:0] S_REV_B   = 4'd8;
	localparam logic [3:0] S_REV_W1  = 4'd9;
	localparam logic [3:0] S_REV_W2  = 4'd10;
	localparam logic [3:0] S_DONE    = 4'd11;

	// entry storage: one write port, one registered read port
	logic [WW-1:0] mem [DEPTH];
	logic [WW-1:0] rd_data_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic [WW-1:0] mem_wdata;

	logic [3:0]          state_q;
	lss_pkg::op_t        op_q;
	lss_pkg::cap_t       cap_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       idx_q;
	logic [AW-1:0]       lo_q;
	logic [AW-1:0]       hi_q;
	logic [WW-1:0]       tmp_q;
	logic [SW-1:0]       acc_q;
	logic [CW-1:0]       rem_q;
	logic [STW-1:0]      step_q;
	logic                sign_q;
	logic                res_ok_q;
	logic [WW-1:0]       res_val_q;

	logic                out_valid_q;
	logic                out_ok_q;
	logic [WW-1:0]       out_val_q;
	logic                out_empty_q;
	logic                out_full_q;

	logic                accept;
	logic                full;
	logic [CW-1:0]       cnt_m1;
	logic                out_load;

	// shared adder/subtractor
	logic [AL-1:0]       alu_a;
	logic [AL-1:0]       alu_b;
	logic                alu_sub;
	logic [AL-1:0]       alu_y;

	logic [AL-1:0]       rd_sx;
	logic [AL-1:0]       best_sx;
	logic                take;
	logic [WW-1:0]       new_best;
	logic [CW:0]         rem_sh;

	assign accept  = req.valid && req.ready;
	assign cnt_m1  = cnt_q - CW'(1);
	// a limit above DEPTH acts as DEPTH; a limit of zero is always full
	assign full    = (CMPW'(cnt_q) >= CMPW'(cap_q)) || (cnt_q == CW'(DEPTH));
	assign req.ready = (state_q == S_IDLE);

	assign rd_sx    = {{(AL-WW){rd_data_q[WW-1]}}, rd_data_q};
	assign best_sx  = {{(AL-WW){acc_q[WW-1]}}, acc_q[WW-1:0]};
	assign rem_sh   = {rem_q, acc_q[SW-1]};
	assign alu_y    = alu_a + (alu_sub ? ~alu_b : alu_b) + AL'(alu_sub);
	// both compares are arranged so a negative difference means "replace"
	assign take     = (idx_q == '0) || alu_y[AL-1];
	assign new_best = take ? rd_data_q : acc_q[WW-1:0];

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			S_SCAN_OP: begin
				if (op_q == lss_pkg::OP_MEAN) begin
					alu_a = {acc_q[SW-1], acc_q};
					alu_b = rd_sx;
				end else if (op_q == lss_pkg::OP_MIN) begin
					alu_a   = rd_sx;
					alu_b   = best_sx;
					alu_sub = 1'b1;
				end else begin
					alu_a   = best_sx;
					alu_b   = rd_sx;
					alu_sub = 1'b1;
				end
			end
			S_ABS: begin
				alu_b   = {acc_q[SW-1], acc_q};
				alu_sub = 1'b1;
			end
			S_DIV: begin
				alu_a   = AL'(rem_sh);
				alu_b   = AL'(cnt_q);
				alu_sub = 1'b1;
			end
			S_NEG: begin
				alu_b   = {1'b0, acc_q};
				alu_sub = 1'b1;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = lo_q;
		mem_wdata = rd_data_q;
		mem_raddr = idx_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				mem_raddr = cnt_m1[AW-1:0];
				mem_waddr = cnt_q[AW-1:0];
				mem_wdata = req.value_in;
				mem_we    = accept && (req.operation == lss_pkg::OP_PUSH) && !full;
			end
			S_REV_A: mem_raddr = lo_q;
			S_REV_B: mem_raddr = hi_q;
			S_REV_W1: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q;
				mem_wdata = rd_data_q;
			end
			S_REV_W2: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = tmp_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lss_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q      <= req.operation;
						res_ok_q  <= 1'b0;
						res_val_q <= '0;
						idx_q     <= '0;
						acc_q     <= '0;
						lo_q      <= '0;
						hi_q      <= cnt_m1[AW-1:0];
						state_q   <= S_DONE;
						case (req.operation)
							lss_pkg::OP_PUSH: begin
								if (!full) begin
									cnt_q    <= cnt_q + CW'(1);
									res_ok_q <= 1'b1;
								end
							end
							lss_pkg::OP_POP, lss_pkg::OP_PEEK: begin
								if (cnt_q != '0) begin
									res_ok_q <= 1'b1;
									state_q  <= S_LOAD;
									if (req.operation == lss_pkg::OP_POP) begin
										cnt_q <= cnt_m1;
									end
								end
							end
							lss_pkg::OP_REVERSE: begin
								res_ok_q <= 1'b1;
								if (cnt_q > CW'(1)) begin
									state_q <= S_REV_A;
								end
							end
							lss_pkg::OP_MIN, lss_pkg::OP_MAX, lss_pkg::OP_MEAN: begin
								if (cnt_q != '0) begin
									res_ok_q <= 1'b1;
									state_q  <= S_SCAN_RD;
								end
							end
							default: begin
								res_ok_q <= 1'b0;
							end
						endcase
					end
				end
				S_LOAD: begin
					res_val_q <= rd_data_q;
					state_q   <= S_DONE;
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_OP;
				end
				S_SCAN_OP: begin
					if (op_q == lss_pkg::OP_MEAN) begin
						acc_q <= alu_y[SW-1:0];
					end else begin
						acc_q <= {{(SW-WW){new_best[WW-1]}}, new_best};
					end
					if (idx_q == cnt_m1) begin
						if (op_q == lss_pkg::OP_MEAN) begin
							state_q <= S_ABS;
						end else begin
							res_val_q <= new_best;
							state_q   <= S_DONE;
						end
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_ABS: begin
					// divide the magnitude, restore the sign afterwards
					sign_q <= acc_q[SW-1];
					if (acc_q[SW-1]) begin
						acc_q <= alu_y[SW-1:0];
					end
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (!alu_y[AL-1]) begin
						rem_q <= alu_y[CW-1:0];
						acc_q <= {acc_q[SW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[CW-1:0];
						acc_q <= {acc_q[SW-2:0], 1'b0};
					end
					if (step_q == STW'(SW - 1)) begin
						state_q <= S_NEG;
					end else begin
						step_q <= step_q + STW'(1);
					end
				end
				S_NEG: begin
					res_val_q <= sign_q ? alu_y[WW-1:0] : acc_q[WW-1:0];
					state_q   <= S_DONE;
				end
				S_REV_A: begin
					state_q <= S_REV_B;
				end
				S_REV_B: begin
					tmp_q   <= rd_data_q;
					state_q <= S_REV_W1;
				end
				S_REV_W1: begin
					state_q <= S_REV_W2;
				end
				S_REV_W2: begin
					lo_q <= lo_q + AW'(1);
					hi_q <= hi_q - AW'(1);
					if ((AW + 1)'(hi_q - lo_q) > (AW + 1)'(2)) begin
						state_q <= S_REV_A;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register: load when free or being taken this cycle
	assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ok_q    <= res_ok_q;
			out_val_q   <= res_val_q;
			out_empty_q <= (cnt_q == '0);
			out_full_q  <= full;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.ok        = out_ok_q;
	assign rsp.value_out = out_val_q;
	assign rsp.is_empty  = out_empty_q;
	assign rsp.is_full   = out_full_q;

	// a refused push leaves the stack as it was
	a_push_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.operation == lss_pkg::OP_PUSH && full) |=> $stable(cnt_q))
		else $error("refused push changed the entry count");

	// a pop on a non-empty stack drops exactly one entry
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.operation == lss_pkg::OP_POP && cnt_q != '0)
		|=> (cnt_q == $past(cnt_m1)))
		else $error("pop did not drop one entry");

	// a new result appears only when the sequencer finishes a command
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result loaded outside the finish step");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
	import lss_pkg::*;

	localparam int   STACK_DEPTH  = DEPTH_DEF;
	localparam int   CYCLE_LIMIT  = 1_500_000;
	localparam int   HOLD_CYCLES  = 300;
	localparam int   TAIL_CYCLES  = 200;
	localparam op_t  OP_UNDEFINED = 3'd7;
	localparam word_t WORD_MIN    = {1'b1, {(WORD_W-1){1'b0}}};
	localparam word_t WORD_MAX    = {1'b0, {(WORD_W-1){1'b1}}};

	typedef struct {
		logic  ok;
		word_t value;
		logic  empty;
		logic  full;
	} stack_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	cap_t cfg_wr_data;

	lss_in_if  req_if ();
	lss_out_if rsp_if ();

	lifo_stack_with_stats #(
		.DEPTH(STACK_DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req_if),
		.rsp        (rsp_if)
	);

	// Shadow copy of the stack and its capacity register.
	word_t stack_mem [STACK_DEPTH];
	int unsigned stack_count;
	cap_t cap_limit;

	stack_result_t pending_results [$];
	int  fail_count;
	int  cycle_count;
	bit  idle_on;
	bit  fill_up;
	bit  rx_hold_req;
	int  rx_hold_left;
	int  rx_burst_left;

	always #5 clk = ~clk;

	function automatic int unsigned effective_limit();
		return (cap_limit > STACK_DEPTH) ? STACK_DEPTH : cap_limit;
	endfunction

	// Apply one command to the shadow stack and return the result it owes.
	function automatic stack_result_t stack_apply(op_t op, word_t word);
		stack_result_t r;
		word_t  tmp;
		longint sum;
		longint mean_q;
		r.ok    = 1'b0;
		r.value = '0;
		case (op)
			OP_PUSH: begin
				if (stack_count < effective_limit()) begin
					stack_mem[stack_count] = word;
					stack_count++;
					r.ok = 1'b1;
				end
			end
			OP_POP: begin
				if (stack_count > 0) begin
					stack_count--;
					r.value = stack_mem[stack_count];
					r.ok    = 1'b1;
				end
			end
			OP_PEEK: begin
				if (stack_count > 0) begin
					r.value = stack_mem[stack_count-1];
					r.ok    = 1'b1;
				end
			end
			OP_REVERSE: begin
				for (int i = 0; i < stack_count / 2; i++) begin
					tmp                         = stack_mem[i];
					stack_mem[i]                = stack_mem[stack_count-1-i];
					stack_mem[stack_count-1-i]  = tmp;
				end
				r.ok = 1'b1;
			end
			OP_MIN, OP_MAX: begin
				if (stack_count > 0) begin
					r.value = stack_mem[0];
					for (int i = 1; i < stack_count; i++) begin
						if (op == OP_MIN ? (stack_mem[i] < r.value) : (stack_mem[i] > r.value))
							r.value = stack_mem[i];
					end
					r.ok = 1'b1;
				end
			end
			OP_MEAN: begin
				if (stack_count > 0) begin
					sum = 0;
					for (int i = 0; i < stack_count; i++)
						sum += longint'(stack_mem[i]);
					// signed division truncates toward zero
					mean_q  = sum / longint'(stack_count);
					r.value = mean_q[WORD_W-1:0];
					r.ok    = 1'b1;
				end
			end
			default: ;
		endcase
		r.empty = (stack_count == 0);
		r.full  = (stack_count >= effective_limit());
		return r;
	endfunction

	// Random walk over the fill level: mostly push on the way up, pop on the
	// way down, with reads, statistics and the odd stray code mixed in.
	function automatic op_t pick_op();
		int unsigned roll;
		if (stack_count == 0)
			fill_up = 1'b1;
		else if (stack_count >= effective_limit())
			fill_up = 1'b0;
		else if ($urandom_range(0, 19) == 0)
			fill_up = !fill_up;
		roll = $urandom_range(0, 99);
		if (roll < 45) return fill_up ? OP_PUSH : OP_POP;
		if (roll < 55) return fill_up ? OP_POP : OP_PUSH;
		if (roll < 68) return OP_PEEK;
		if (roll < 74) return OP_REVERSE;
		if (roll < 81) return OP_MIN;
		if (roll < 88) return OP_MAX;
		if (roll < 95) return OP_MEAN;
		return op_t'($urandom_range(0, 7));
	endfunction

	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
			0:       return WORD_MIN;
			1:       return WORD_MAX;
			2, 3:    return word_t'($urandom_range(0, 16)) - 8;
			default: return word_t'($urandom);
		endcase
	endfunction

	// Offer one command, optionally after an idle burst, and hold it until the
	// transfer. Record the expected result at the accepting edge.
	task automatic send_cmd(op_t op, word_t word);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.operation <= op;
		req_if.value_in  <= word;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		pending_results.push_back(stack_apply(op, word));
	endtask

	// Drop valid and wait until every expected result has come back.
	task automatic wait_idle();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_capacity(cap_t lim);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= lim;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cap_limit = lim;
	endtask

	task automatic report_mismatch(string field, longint want, longint got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		fail_count++;
	endtask

	// The refusal paths on an empty stack and a reverse of it, plus a stray operation code.
	task automatic test_empty_stack();
		send_cmd(OP_POP, pick_word());
		send_cmd(OP_PEEK, pick_word());
		send_cmd(OP_REVERSE, pick_word());
		send_cmd(OP_MIN, pick_word());
		send_cmd(OP_MAX, pick_word());
		send_cmd(OP_MEAN, pick_word());
		send_cmd(OP_UNDEFINED, WORD_MAX);
	endtask

	// Word extremes; the mean of these four is -1.5 and must truncate to -1.
	task automatic test_extremes();
		send_cmd(OP_PUSH, WORD_MIN);
		send_cmd(OP_PUSH, WORD_MAX);
		send_cmd(OP_PUSH, -1);
		send_cmd(OP_PUSH, -4);
		send_cmd(OP_MIN, '0);
		send_cmd(OP_MAX, '0);
		send_cmd(OP_MEAN, '0);
		send_cmd(OP_REVERSE, '0);
		send_cmd(OP_PEEK, '0);
		send_cmd(OP_POP, '0);
		send_cmd(OP_PEEK, '0);
	endtask

	// Limit lowered below the fill level, a zero limit (full and empty at
	// once), then a limit above the depth.
	task automatic test_capacity_limits();
		set_capacity(7'd2);
		send_cmd(OP_PUSH, 32'sd17);
		send_cmd(OP_POP, '0);
		set_capacity(7'd0);
		send_cmd(OP_POP, '0);
		send_cmd(OP_POP, '0);
		send_cmd(OP_PUSH, 32'sd5);
		set_capacity(7'd127);
		send_cmd(OP_PUSH, 32'sd9);
	endtask

	// Stall the response side for a long stretch while commands keep coming,
	// so the block has to hold off its input.
	task automatic test_back_pressure();
		wait_idle();
		rx_hold_req = 1'b1;
		repeat (12) send_cmd(pick_op(), pick_word());
	endtask

	task automatic test_random_traffic();
		cap_t caps [8];
		int   n;
		caps    = '{7'd127, 7'd1, 7'd64, 7'd0, 7'd5, 7'd1, 7'd2, 7'd64};
		caps[5] = cap_t'($urandom_range(1, 64));
		foreach (caps[p]) begin
			set_capacity(caps[p]);
			idle_on = (p % 3 != 2);
			n = (caps[p] == 0) ? 40 : 150;
			repeat (n) send_cmd(pick_op(), pick_word());
		end
	endtask

	// Close with back-to-back traffic: no idling on either side.
	task automatic test_full_rate();
		set_capacity(7'd64);
		idle_on = 1'b0;
		repeat (300) send_cmd(pick_op(), pick_word());
	endtask

	// Response side: random stall bursts, or one long hold when requested.
	always @(negedge clk) begin
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			rsp_if.ready <= 1'b0;
		end else if (rx_hold_req) begin
			rx_hold_req  = 1'b0;
			rx_hold_left = HOLD_CYCLES - 1;
			rsp_if.ready <= 1'b0;
		end else if (!idle_on) begin
			rx_burst_left = 0;
			rsp_if.ready <= 1'b1;
		end else if (rx_burst_left != 0) begin
			rx_burst_left--;
			rsp_if.ready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			rx_burst_left = $urandom_range(1, 11) - 1;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin : check_results
		stack_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected, actual ok %0b value %0d", $time,
					rsp_if.ok, rsp_if.value_out);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_if.ok !== want.ok)
					report_mismatch("ok", want.ok, rsp_if.ok);
				if (rsp_if.value_out !== want.value)
					report_mismatch("value_out", want.value, rsp_if.value_out);
				if (rsp_if.is_empty !== want.empty)
					report_mismatch("is_empty", want.empty, rsp_if.is_empty);
				if (rsp_if.is_full !== want.full)
					report_mismatch("is_full", want.full, rsp_if.is_full);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_wr_data      = '0;
		req_if.valid     = 1'b0;
		req_if.operation = OP_PUSH;
		req_if.value_in  = '0;
		rsp_if.ready     = 1'b0;
		stack_count      = 0;
		cap_limit        = CAP_RESET;
		fail_count       = 0;
		cycle_count      = 0;
		idle_on          = 1'b1;
		fill_up          = 1'b1;
		rx_hold_req      = 1'b0;
		rx_hold_left     = 0;
		rx_burst_left    = 0;
		foreach (stack_mem[k])
			stack_mem[k] = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_stack();
		test_extremes();
		test_capacity_limits();
		test_back_pressure();
		test_random_traffic();
		test_full_rate();

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
